// ===== rtl/core/bb3_pkg.sv =====
// Shared constants for the 3x3 RGB box blur.
// Register indexes, reset values, field widths and the divide-by-nine reciprocal.
// No dependencies.
package bb3_pkg;

    localparam int PIX_W        = 8;
    localparam int RGB_W        = 3 * PIX_W;
    localparam int ROW_W        = 12;
    localparam int COL_W        = 11;
    localparam int CFG_W        = 12;
    localparam int CFG_INDEX_W  = 2;
    localparam int COLSUM_W     = 10;
    localparam int SUM_W        = 12;

    localparam int DEF_MAX_WIDTH = 2048;

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 12'd640;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 12'd480;
    localparam logic [CFG_W-1:0] MIN_DIM          = 12'd3;

    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

    // floor(sum * RECIP_9 >> RECIP_SHIFT) == floor(sum / 9) for sum <= 9 * 255
    localparam int RECIP_W     = 13;
    localparam int RECIP_SHIFT = 16;
    localparam logic [RECIP_W-1:0] RECIP_9 = 13'd7282;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 48;

endpackage

// ===== rtl/core/bb3_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module bb3_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/box_blur_3x3_rgb.sv =====
// 3x3 box blur over a raster RGB pixel stream: per-channel truncated mean of nine.
// A pixel is held in stage 1, then its result in the output registers; one pixel per cycle
// sustained unless the output stalls, set by the single line-store RAM port pair (read at
// accept, write as the pixel leaves stage 1). Border centres give no result. Synchronous
// active-low reset clears counters, window and handshake state; the line store is not cleared.
// Depends on bb3_pkg and bb3_ram.
module box_blur_3x3_rgb #(
    parameter int MAX_WIDTH = bb3_pkg::DEF_MAX_WIDTH
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bb3_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [bb3_pkg::CFG_W-1:0]           cfg_data,
    // pixel in
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [bb3_pkg::S_TDATA_W-1:0]       s_tdata,  // blue_in, green_in, red_in
    // result out
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [bb3_pkg::M_TDATA_W-1:0]       m_tdata,  // blue_out, green_out, red_out,
                                                          // center_row, center_col, 1'b0
    output logic                                m_tlast   // frame_last
);
    import bb3_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int CW = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;
    localparam logic [CW-1:0] MAXW      = CW'(MAX_WIDTH);
    localparam logic [AW-1:0] ADDR_LAST = AW'(MAX_WIDTH - 1);

    // configuration
    logic [CFG_W-1:0] frame_width_reg, frame_height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    logic [CW-1:0]    w_eff;
    logic [CFG_W-1:0] h_eff;

    always_comb begin
        if (frame_width_reg < MIN_DIM) begin
            w_eff = CW'(MIN_DIM);
        end else if (CW'(frame_width_reg) > MAXW) begin
            w_eff = MAXW;
        end else begin
            w_eff = CW'(frame_width_reg);
        end
        h_eff = (frame_height_reg < MIN_DIM) ? MIN_DIM : frame_height_reg;
    end

    // stage 0: position counters
    logic [ROW_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [AW-1:0]    addr_reg, addr_next;
    logic             s_accept;
    logic [ROW_W:0]   row_inc;
    logic [COL_W:0]   col_inc;
    logic             hit0, last0;

    always_comb begin
        row_inc   = {1'b0, row_reg} + 1'b1;
        col_inc   = {1'b0, col_reg} + 1'b1;
        row_next  = row_reg;
        col_next  = col_inc[COL_W-1:0];
        addr_next = (addr_reg == ADDR_LAST) ? '0 : addr_reg + 1'b1;
        if (CW'(col_inc) >= w_eff) begin
            col_next = '0;
            row_next = (row_inc >= {1'b0, h_eff}) ? '0 : row_inc[ROW_W-1:0];
        end
        if (col_next == '0) begin
            addr_next = '0;
        end
        hit0  = (row_reg >= ROW_W'(2)) && (col_reg >= COL_W'(2))
              && (row_reg < h_eff) && (CW'(col_reg) < w_eff);
        last0 = (row_reg == h_eff - 1'b1) && (CW'(col_reg) == w_eff - 1'b1);
    end

    // stage 1 and output registers
    logic             v1_reg, hit1_reg, last1_reg;
    logic [RGB_W-1:0] px1_reg;
    logic [AW-1:0]    addr1_reg;
    logic [ROW_W-1:0] row1_reg;
    logic [COL_W-1:0] col1_reg;
    logic             adv;

    logic [COLSUM_W-1:0] wsum0_reg [3];
    logic [COLSUM_W-1:0] wsum1_reg [3];

    logic                 m_tvalid_reg, m_tlast_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    assign adv      = v1_reg && (!m_tvalid_reg || m_tready);
    assign s_tready = !v1_reg || adv;
    assign s_accept = s_tvalid && s_tready;

    // line store: [RGB_W-1:0] row r-1, [2*RGB_W-1:RGB_W] row r-2
    logic [2*RGB_W-1:0] ls_rdata;

    bb3_ram #(
        .WIDTH (2 * RGB_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .aclk  (aclk),
        .we    (adv),
        .waddr (addr1_reg),
        .wdata ({ls_rdata[RGB_W-1:0], px1_reg}),
        .re    (s_accept),
        .raddr (addr_reg),
        .rdata (ls_rdata)
    );

    logic [COLSUM_W-1:0]        cur_sum [3];
    logic [SUM_W-1:0]           tot_sum [3];
    logic [SUM_W+RECIP_W-1:0]   prod    [3];
    logic [PIX_W-1:0]           mean    [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            cur_sum[k] = COLSUM_W'(px1_reg[k*PIX_W +: PIX_W])
                       + COLSUM_W'(ls_rdata[k*PIX_W +: PIX_W])
                       + COLSUM_W'(ls_rdata[RGB_W + k*PIX_W +: PIX_W]);
            tot_sum[k] = SUM_W'(cur_sum[k]) + SUM_W'(wsum0_reg[k]) + SUM_W'(wsum1_reg[k]);
            prod[k]    = tot_sum[k] * RECIP_9;
            mean[k]    = prod[k][RECIP_SHIFT +: PIX_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg      <= '0;
            col_reg      <= '0;
            addr_reg     <= '0;
            v1_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                wsum0_reg[k] <= '0;
                wsum1_reg[k] <= '0;
            end
        end else begin
            if (s_accept) begin
                row_reg   <= row_next;
                col_reg   <= col_next;
                addr_reg  <= addr_next;
                px1_reg   <= s_tdata[RGB_W-1:0];
                addr1_reg <= addr_reg;
                hit1_reg  <= hit0;
                last1_reg <= last0;
                row1_reg  <= row_reg - 1'b1;
                col1_reg  <= col_reg - 1'b1;
            end
            if (s_accept) begin
                v1_reg <= 1'b1;
            end else if (adv) begin
                v1_reg <= 1'b0;
            end
            if (adv) begin
                for (int k = 0; k < 3; k++) begin
                    wsum1_reg[k] <= wsum0_reg[k];
                    wsum0_reg[k] <= cur_sum[k];
                end
                m_tvalid_reg <= hit1_reg;
                m_tlast_reg  <= last1_reg;
                m_tdata_reg  <= {1'b0, col1_reg, row1_reg, mean[2], mean[1], mean[0]};
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

`ifndef SYNTHESIS
    a_no_border_centre: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[35:24] != '0) && (m_tdata[46:36] != '0))
        else $error("result for a border centre");

    a_stall_only_on_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output backpressure");

    a_result_from_stage1: assert property (@(posedge aclk) disable iff (!aresetn)
        !$past(v1_reg) && !$past(m_tvalid) |-> !m_tvalid)
        else $error("result without a pixel in flight");
`endif

endmodule

// ===== tb/sv/box_blur_3x3_rgb_tb.sv =====
// Self-checking testbench for box_blur_3x3_rgb: streams RGB frames under several geometries,
// predicts every 3x3 mean in a scoreboard class and checks results in arrival order.
// Depends on bb3_pkg and the box_blur_3x3_rgb RTL.
module box_blur_3x3_rgb_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bb3_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_3 = 2'd3;
    localparam int LINE_DEPTH = DEF_MAX_WIDTH;

    typedef struct packed {
        logic [7:0]       blue;
        logic [7:0]       green;
        logic [7:0]       red;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
    } blur_t;

    typedef enum {FILL_RANDOM, FILL_WHITE, FILL_BLACK} fill_t;

    class blur_checker;
        logic [CFG_W-1:0] frame_width;
        logic [CFG_W-1:0] frame_height;
        int unsigned      row_pos;
        int unsigned      col_pos;
        logic [RGB_W-1:0] line_prev[LINE_DEPTH];
        logic [RGB_W-1:0] line_prev2[LINE_DEPTH];
        logic [RGB_W-1:0] win[3][3];
        blur_t            expected_means[$];
        int               fail_count;

        function new();
            frame_width  = FRAME_WIDTH_RST;
            frame_height = FRAME_HEIGHT_RST;
            row_pos      = 0;
            col_pos      = 0;
            fail_count   = 0;
            foreach (line_prev[i]) begin
                line_prev[i]  = '0;
                line_prev2[i] = '0;
            end
            foreach (win[i, j]) win[i][j] = '0;
        endfunction

        function int pending();
            return expected_means.size();
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_W-1:0] value);
            case (index)
                CFG_FRAME_WIDTH:  frame_width  = value;
                CFG_FRAME_HEIGHT: frame_height = value;
                default: ;
            endcase
        endfunction

        function logic [7:0] lane_mean(int lane);
            int unsigned total;
            total = 0;
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    total += (win[i][j] >> (8 * lane)) & 24'hFF;
            return 8'(total / 9);
        endfunction

        function void note_pixel(logic [RGB_W-1:0] px);
            int unsigned w, h, r, c, idx;
            logic [RGB_W-1:0] above2, above1;
            blur_t m;
            w = (frame_width < MIN_DIM) ? MIN_DIM :
                ((frame_width > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : frame_width);
            h = (frame_height < MIN_DIM) ? MIN_DIM : frame_height;
            r = row_pos;
            c = col_pos;
            idx = c % LINE_DEPTH;
            above2 = line_prev2[idx];
            above1 = line_prev[idx];
            line_prev2[idx] = above1;
            line_prev[idx]  = px;
            for (int i = 0; i < 3; i++) begin
                win[0][i] = win[1][i];
                win[1][i] = win[2][i];
            end
            win[2][0] = above2;
            win[2][1] = above1;
            win[2][2] = px;
            if (r >= 2 && c >= 2 && r < h && c < w) begin
                m.blue  = lane_mean(0);
                m.green = lane_mean(1);
                m.red   = lane_mean(2);
                m.row   = ROW_W'(r - 1);
                m.col   = COL_W'(c - 1);
                m.last  = (r == h - 1) && (c == w - 1);
                expected_means.push_back(m);
            end
            c++;
            if (c >= w) begin
                c = 0;
                r++;
                if (r >= h) r = 0;
            end
            col_pos = c & 32'h7FF;
            row_pos = r & 32'hFFF;
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] d, logic last);
            blur_t got, want;
            string exp_s, got_s;
            got.blue  = d[7:0];
            got.green = d[15:8];
            got.red   = d[23:16];
            got.row   = d[35:24];
            got.col   = d[46:36];
            got.last  = last;
            if (expected_means.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("%t unexpected result: b=%0d g=%0d r=%0d row=%0d col=%0d last=%0b",
                             $realtime, got.blue, got.green, got.red, got.row, got.col,
                             got.last);
                return;
            end
            want = expected_means.pop_front();
            if (got !== want) begin
                fail_count++;
                if (fail_count <= 10) begin
                    exp_s = $sformatf("b=%0d g=%0d r=%0d row=%0d col=%0d last=%0b",
                                      want.blue, want.green, want.red, want.row, want.col,
                                      want.last);
                    got_s = $sformatf("b=%0d g=%0d r=%0d row=%0d col=%0d last=%0b",
                                      got.blue, got.green, got.red, got.row, got.col,
                                      got.last);
                    $display("%t mismatch: expected %s, got %s", $realtime, exp_s, got_s);
                end
            end
        endfunction
    endclass

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]       cfg_data = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata = '0;   // blue_in, green_in, red_in
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;        // blue_out, green_out, red_out, center_row,
                                            // center_col, zero pad
    logic                   m_tlast;        // frame_last

    blur_checker sb;
    bit          s_idle_en = 1'b1;
    bit          m_idle_en = 1'b1;
    fill_t       fill_kind = FILL_WHITE;
    int          pixels_sent = 0;

    box_blur_3x3_rgb u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #4 aclk = ~aclk;

    function automatic logic [RGB_W-1:0] next_pixel();
        case (fill_kind)
            FILL_WHITE: return 24'hFFFFFF;
            FILL_BLACK: return 24'h000000;
            default: begin
                case ($urandom_range(0, 15))
                    0:       return 24'hFFFFFF;
                    1:       return 24'h000000;
                    default: return 24'($urandom());
                endcase
            end
        endcase
    endfunction

    task automatic send_pixel(input logic [RGB_W-1:0] px);
        int gap;
        gap = (s_idle_en && $urandom_range(0, 5) == 0) ? $urandom_range(1, 4) : 0;
        @(negedge aclk);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        do @(posedge aclk); while (!s_tready);
        sb.note_pixel(px);
        pixels_sent++;
    endtask

    // drop the request and hold until every expected result is back
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index, input logic [CFG_W-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(index, value);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic finish_frame();
        do send_pixel(next_pixel()); while (sb.row_pos != 0 || sb.col_pos != 0);
    endtask

    task automatic run_frame(input int w, input int h);
        settle();
        write_reg(CFG_FRAME_WIDTH, CFG_W'(w));
        write_reg(CFG_FRAME_HEIGHT, CFG_W'(h));
        finish_frame();
    endtask

    initial begin
        int stall;
        stall = 0;
        forever begin
            @(negedge aclk);
            if (stall != 0) begin
                m_tready <= 1'b0;
                stall--;
            end else if (m_idle_en && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                stall = $urandom_range(0, 3);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast);
    end

    initial begin
        #10_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        int w, h, ew, eh, goal;
        sb = new();
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // start of row 0 under the reset geometry, then shrink mid-frame with clamped values
        repeat (3) send_pixel(next_pixel());
        settle();
        write_reg(CFG_FRAME_WIDTH, 12'd0);
        write_reg(CFG_FRAME_HEIGHT, 12'd2);
        write_reg(CFG_SPARE_2, 12'hFFF);
        write_reg(CFG_SPARE_3, 12'hAAA);
        finish_frame();
        fill_kind = FILL_BLACK;
        finish_frame();

        // oversized width, then oversized height, each cut short mid-frame
        fill_kind = FILL_RANDOM;
        settle();
        write_reg(CFG_FRAME_WIDTH, 12'hFFF);
        write_reg(CFG_FRAME_HEIGHT, 12'd3);
        repeat (200) send_pixel(next_pixel());
        settle();
        write_reg(CFG_FRAME_WIDTH, 12'd5);
        finish_frame();

        settle();
        write_reg(CFG_FRAME_WIDTH, 12'd3);
        write_reg(CFG_FRAME_HEIGHT, 12'hFFF);
        repeat (61) send_pixel(next_pixel());
        settle();
        write_reg(CFG_FRAME_HEIGHT, 12'd9);
        finish_frame();

        goal = 1850;
        while (pixels_sent < goal) begin
            s_idle_en = (goal - pixels_sent > 300) && $urandom_range(0, 3) != 0;
            m_idle_en = (goal - pixels_sent > 300) && $urandom_range(0, 3) != 0;
            case ($urandom_range(0, 9))
                0:       w = $urandom_range(0, 2);
                1:       w = $urandom_range(11, 40);
                default: w = $urandom_range(3, 10);
            endcase
            h = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 7);
            if ($urandom_range(0, 4) == 0) begin
                ew = (w < 3) ? 3 : w;
                eh = (h < 3) ? 3 : h;
                settle();
                write_reg(CFG_FRAME_WIDTH, CFG_W'(w));
                write_reg(CFG_FRAME_HEIGHT, CFG_W'(h));
                repeat ($urandom_range(1, ew * eh - 1)) send_pixel(next_pixel());
                settle();
                if (ew > 3 && $urandom_range(0, 1) == 1)
                    write_reg(CFG_FRAME_WIDTH, CFG_W'($urandom_range(0, ew - 1)));
                else
                    write_reg(CFG_FRAME_HEIGHT, CFG_W'($urandom_range(0, 9)));
                finish_frame();
            end else begin
                run_frame(w, h);
            end
        end

        s_idle_en = 1'b0;
        m_idle_en = 1'b0;
        settle();
        if (sb.fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

// ===== files.f =====
rtl/core/bb3_pkg.sv
rtl/core/bb3_ram.sv
rtl/core/box_blur_3x3_rgb.sv
tb/sv/box_blur_3x3_rgb_tb.sv
